// File: sv/gss_pkg.sv
`timescale 1ns / 1ps
// Package for the Gauss-Seidel solver: widths, codes, state encoding and the
// structs that travel between the controller and the cell chain. No dependencies.
`default_nettype none
package gss_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int N_W       = 7;
    localparam int ACC_W     = 56;
    localparam int TERM_W    = 48;
    localparam int CNT_W     = 16;
    localparam int MAX_N_DEF = 16;

    localparam logic [4:0]  SIZE_RST  = 5'd16;
    localparam logic [15:0] TOL_RST   = 16'd7;
    localparam logic [15:0] SWEEP_RST = 16'd1000;

    localparam logic [ACC_W-1:0] NUM_LIM = ACC_W'(64'h0000_7FFF_FFFF_FFFF);

    typedef enum logic [1:0] {
        REG_SIZE  = 2'd0,
        REG_TOL   = 2'd1,
        REG_SWEEP = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        KIND_COEF  = 2'd0,
        KIND_RHS   = 2'd1,
        KIND_GUESS = 2'd2,
        KIND_SOLVE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_CONV  = 2'd0,
        ST_LIMIT = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_PASS,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [N_W-1:0]    n;
        logic              wr_coef;
        logic              wr_rhs;
        logic              wr_sol;
        logic [IDX_W-1:0]  wr_row;
        logic [IDX_W-1:0]  wr_col;
        logic [DATA_W-1:0] wr_data;
    } t_cell_ctl;

    typedef struct packed {
        logic              tok;
        logic [ACC_W-1:0]  acc;
        logic [DATA_W-1:0] old;
        logic [DATA_W-1:0] diag;
    } t_link;

endpackage
`default_nettype wire

// File: sv/gss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for solver input and result transactions.
// Depends on nothing.
`default_nettype none
interface gss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] value;
    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface gss_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic signed [31:0] solution;
    logic        last;
    logic [1:0]  status;
    logic [15:0] sweeps;
    modport source (output valid, index, solution, last, status, sweeps, input ready);
    modport sink   (input valid, index, solution, last, status, sweeps, output ready);
endinterface
`default_nettype wire

// File: sv/gss_cell.sv
`timescale 1ns / 1ps
// One cell of the solver chain: holds one unknown, its rhs, its diagonal and one
// column of the matrix, and adds its term to the passing row sum. Uses gss_pkg.
`default_nettype none
module gss_cell #(
    parameter int MAX_N = gss_pkg::MAX_N_DEF,
    parameter int K     = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  gss_pkg::t_cell_ctl i_ctl,
    input  gss_pkg::t_link    i_link,
    output gss_pkg::t_link    o_link,
    output logic              o_zero
);
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic signed [31:0] r_mem [MAX_N];
    logic signed [31:0] r_a;
    logic signed [31:0] r_x;
    logic signed [31:0] r_b;
    logic signed [31:0] r_diag;
    logic signed [63:0] r_prod;
    logic signed [gss_pkg::TERM_W-1:0] r_term;
    gss_pkg::t_link     r_link;

    logic               is_row;
    logic               in_use;
    logic signed [gss_pkg::ACC_W-1:0] contrib;
    logic [gss_pkg::TERM_W-1:0] term_sh;

    assign is_row = (i_ctl.row == gss_pkg::IDX_W'(K));
    assign in_use = (gss_pkg::N_W'(K) < i_ctl.n);
    assign term_sh = r_prod[63:16];

    always_comb begin
        if (is_row) begin
            contrib = gss_pkg::ACC_W'(r_b);
        end else if (in_use) begin
            contrib = -gss_pkg::ACC_W'(r_term);
        end else begin
            contrib = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_coef && i_ctl.wr_col == gss_pkg::IDX_W'(K)) begin
            r_mem[i_ctl.wr_row[AW-1:0]] <= i_ctl.wr_data;
        end
        r_a <= r_mem[i_ctl.row[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_coef && i_ctl.wr_col == gss_pkg::IDX_W'(K)
                && i_ctl.wr_row == gss_pkg::IDX_W'(K)) begin
            r_diag <= i_ctl.wr_data;
        end
        if (i_ctl.wr_rhs && i_ctl.wr_row == gss_pkg::IDX_W'(K)) begin
            r_b <= i_ctl.wr_data;
        end
        if (i_ctl.wr_sol && i_ctl.wr_row == gss_pkg::IDX_W'(K)) begin
            r_x <= i_ctl.wr_data;
        end
        r_prod <= r_a * r_x;
        if (r_prod[63] && (r_prod[15:0] != 16'd0)) begin
            r_term <= term_sh + gss_pkg::TERM_W'(1);
        end else begin
            r_term <= term_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
        end else begin
            r_link.tok <= i_link.tok;
        end
        r_link.acc  <= i_link.acc + contrib;
        r_link.old  <= is_row ? r_x : i_link.old;
        r_link.diag <= is_row ? r_diag : i_link.diag;
    end

    assign o_link = r_link;
    assign o_zero = (r_diag == 32'sd0) && in_use;
endmodule
`default_nettype wire

// File: sv/gss_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: clamps the row numerator,
// divides numerator * 2^16 by the diagonal and saturates to 32 bits. Uses gss_pkg.
`default_nettype none
module gss_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [gss_pkg::ACC_W-1:0]         i_num,
    input  wire [31:0]                       i_den,
    output logic                             o_done,
    output logic signed [31:0]               o_quot
);
    localparam int DQ_W = 63;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [32:0]       r_rem;
    logic [DQ_W-1:0]   r_dq;
    logic [31:0]       r_den;
    logic              r_neg;

    logic              num_neg;
    logic [gss_pkg::ACC_W-1:0] num_abs;
    logic [46:0]       num_mag;
    logic [32:0]       rem_sh;
    logic              ge;

    assign num_neg = i_num[gss_pkg::ACC_W-1];
    assign num_abs = num_neg ? -i_num : i_num;
    assign num_mag = (num_abs > gss_pkg::NUM_LIM) ? gss_pkg::NUM_LIM[46:0] : num_abs[46:0];
    assign rem_sh  = {r_rem[31:0], r_dq[DQ_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= {num_mag, 16'd0};
            r_den <= i_den[31] ? -i_den : i_den;
            r_neg <= num_neg ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_dq  <= {r_dq[DQ_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_dq > DQ_W'(64'h8000_0000)) begin
                o_quot = 32'sh8000_0000;
            end else begin
                o_quot = -$signed(r_dq[31:0]);
            end
        end else begin
            if (r_dq > DQ_W'(64'h7FFF_FFFF)) begin
                o_quot = 32'sh7FFF_FFFF;
            end else begin
                o_quot = $signed(r_dq[31:0]);
            end
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// File: sv/gss_ctl.sv
`timescale 1ns / 1ps
// Solver sequencer: takes load and solve transactions, runs row passes through the
// cell chain and the divider, and drives the result register. Uses gss_pkg, gss_if.
`default_nettype none
module gss_ctl #(
    parameter int MAX_N = gss_pkg::MAX_N_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    gss_in_if.sink                    i_in,
    gss_out_if.source                 o_out,
    input  wire [gss_pkg::N_W-1:0]    i_n,
    input  wire [15:0]                i_tol,
    input  wire [15:0]                i_max,
    input  wire                       i_any_zero,
    input  gss_pkg::t_link            i_chain,
    input  wire                       i_div_done,
    input  wire signed [31:0]         i_div_quot,
    output gss_pkg::t_cell_ctl        o_ctl,
    output logic                      o_tok,
    output logic                      o_div_start
);
    gss_pkg::t_state  r_state, n_state;
    logic [gss_pkg::IDX_W-1:0] r_j, n_j;
    logic [1:0]       r_cnt, n_cnt;
    logic [15:0]      r_sweeps, n_sweeps;
    logic [gss_pkg::N_W-1:0] r_settled, n_settled;
    gss_pkg::t_status r_status, n_status;
    logic             r_out_phase, n_out_phase;
    logic             r_ovalid;
    logic signed [31:0] r_old;
    logic [3:0]       r_oindex;
    logic signed [31:0] r_osol;
    logic             r_olast;
    logic [1:0]       r_ostatus;
    logic [15:0]      r_osweeps;

    logic             accept;
    logic             solve_acc;
    logic             row_ok;
    logic             col_ok;
    logic             last_j;
    logic             load_out;
    logic [15:0]      limit;
    logic [15:0]      sweeps_inc;
    logic signed [32:0] diff;
    logic [32:0]      diff_abs;
    logic             settle;
    logic [gss_pkg::N_W-1:0] settled_inc;

    assign accept = i_in.valid && i_in.ready;
    assign solve_acc = accept && (gss_pkg::t_kind'(i_in.kind) == gss_pkg::KIND_SOLVE);
    assign row_ok = ({3'd0, i_in.row} < gss_pkg::N_W'(MAX_N));
    assign col_ok = ({3'd0, i_in.col} < gss_pkg::N_W'(MAX_N));
    assign last_j = (({1'b0, r_j} + gss_pkg::N_W'(1)) == i_n);
    assign load_out = (r_state == gss_pkg::S_EMIT) && (!r_ovalid || o_out.ready);
    assign limit = (i_max == 16'd0) ? 16'd1 : i_max;
    assign sweeps_inc = r_sweeps + 16'd1;
    assign diff = {i_div_quot[31], i_div_quot} - {r_old[31], r_old};
    assign diff_abs = diff[32] ? -diff : diff;
    assign settle = (diff_abs < {17'd0, i_tol});
    assign settled_inc = r_settled + gss_pkg::N_W'(settle);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gss_pkg::S_IDLE: begin
                if (solve_acc) begin
                    n_state = gss_pkg::S_PRE;
                end
            end
            gss_pkg::S_PRE: begin
                if (r_cnt == 2'd3) begin
                    n_state = gss_pkg::S_PASS;
                end
            end
            gss_pkg::S_PASS: begin
                if (i_chain.tok) begin
                    n_state = r_out_phase ? gss_pkg::S_EMIT : gss_pkg::S_DIV;
                end
            end
            gss_pkg::S_DIV: begin
                if (i_div_done) begin
                    n_state = gss_pkg::S_PRE;
                end
            end
            gss_pkg::S_EMIT: begin
                if (load_out) begin
                    n_state = last_j ? gss_pkg::S_IDLE : gss_pkg::S_PRE;
                end
            end
            default: n_state = gss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = (r_state == gss_pkg::S_IDLE);
        o_tok          = (r_state == gss_pkg::S_PRE) && (r_cnt == 2'd3);
        o_div_start    = (r_state == gss_pkg::S_PASS) && i_chain.tok && !r_out_phase;
        o_ctl.row      = r_j;
        o_ctl.n        = i_n;
        o_ctl.wr_coef  = accept && (gss_pkg::t_kind'(i_in.kind) == gss_pkg::KIND_COEF)
                         && row_ok && col_ok;
        o_ctl.wr_rhs   = accept && (gss_pkg::t_kind'(i_in.kind) == gss_pkg::KIND_RHS)
                         && row_ok;
        o_ctl.wr_col   = gss_pkg::IDX_W'(i_in.col);
        if (r_state == gss_pkg::S_DIV) begin
            o_ctl.wr_sol  = i_div_done;
            o_ctl.wr_row  = r_j;
            o_ctl.wr_data = i_div_quot;
        end else begin
            o_ctl.wr_sol  = accept && (gss_pkg::t_kind'(i_in.kind) == gss_pkg::KIND_GUESS)
                            && row_ok;
            o_ctl.wr_row  = gss_pkg::IDX_W'(i_in.row);
            o_ctl.wr_data = i_in.value;
        end
    end

    always_comb begin
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_sweeps    = r_sweeps;
        n_settled   = r_settled;
        n_status    = r_status;
        n_out_phase = r_out_phase;
        unique case (r_state)
            gss_pkg::S_IDLE: begin
                if (solve_acc) begin
                    n_j         = '0;
                    n_cnt       = '0;
                    n_sweeps    = '0;
                    n_settled   = '0;
                    n_out_phase = i_any_zero;
                    n_status    = gss_pkg::ST_ZERO;
                end
            end
            gss_pkg::S_PRE: begin
                n_cnt = r_cnt + 2'd1;
            end
            gss_pkg::S_PASS: begin
                n_cnt = '0;
            end
            gss_pkg::S_DIV: begin
                if (i_div_done) begin
                    if (!last_j) begin
                        n_j       = r_j + gss_pkg::IDX_W'(1);
                        n_settled = settled_inc;
                    end else begin
                        n_j       = '0;
                        n_sweeps  = sweeps_inc;
                        n_settled = '0;
                        if (settled_inc == i_n) begin
                            n_status    = gss_pkg::ST_CONV;
                            n_out_phase = 1'b1;
                        end else if (sweeps_inc >= limit) begin
                            n_status    = gss_pkg::ST_LIMIT;
                            n_out_phase = 1'b1;
                        end
                    end
                end
            end
            gss_pkg::S_EMIT: begin
                if (load_out) begin
                    n_j = r_j + gss_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gss_pkg::S_IDLE;
            r_j         <= '0;
            r_cnt       <= '0;
            r_sweeps    <= '0;
            r_settled   <= '0;
            r_status    <= gss_pkg::ST_CONV;
            r_out_phase <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_sweeps    <= n_sweeps;
            r_settled   <= n_settled;
            r_status    <= n_status;
            r_out_phase <= n_out_phase;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == gss_pkg::S_PASS) && i_chain.tok) begin
            r_old <= i_chain.old;
        end
        if (load_out) begin
            r_oindex  <= r_j[3:0];
            r_osol    <= r_old;
            r_olast   <= last_j;
            r_ostatus <= r_status;
            r_osweeps <= r_sweeps;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.index    = r_oindex;
    assign o_out.solution = r_osol;
    assign o_out.last     = r_olast;
    assign o_out.status   = r_ostatus;
    assign o_out.sweeps   = r_osweeps;

`ifndef SYNTHESIS
    a_tok_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_chain.tok |-> (r_state == gss_pkg::S_PASS))
        else $error("chain token arrived outside a row pass");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == gss_pkg::S_DIV))
        else $error("divider finished outside the divide state");
    a_zero_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == gss_pkg::ST_ZERO)) |-> (o_out.sweeps == 16'd0))
        else $error("zero diagonal result reports sweeps");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gss_pkg::S_PASS) |-> ({1'b0, r_j} < i_n))
        else $error("row pass beyond the active size");
`endif
endmodule
`default_nettype wire

// File: sv/gauss_seidel_solver.sv
`timescale 1ns / 1ps
// Top level of the Gauss-Seidel solver: configuration registers, the cell chain,
// the divider and the sequencer. Uses gss_pkg, gss_if, gss_cell, gss_div, gss_ctl.
//
//   Channel   Kind        Carries
//   i_in      valid/ready kind, row, col, value (load or solve)
//   o_out     valid/ready index, solution, last, status, sweeps
//   APB       psel/penable size_in_use, tolerance, max_sweeps at 0x0, 0x4, 0x8
//
// Load transactions are accepted back to back while idle. A solve holds the input off
// while it runs: each row of a sweep passes through the cell chain and then the divider,
// and each reported component takes a pass through the chain plus any output stall.
// Reset is synchronous and active low; it clears control state only, not the stores.
// A stalled result register holds the sequencer but not the chain's stored data.
`default_nettype none
module gauss_seidel_solver #(
    parameter int MAX_N = gss_pkg::MAX_N_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    gss_in_if.sink      i_in,
    gss_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0]  r_size;
    logic [15:0] r_tol;
    logic [15:0] r_max;
    logic [gss_pkg::N_W-1:0] eff_n;

    gss_pkg::t_cell_ctl ctl;
    gss_pkg::t_link     links [MAX_N+1];
    logic [MAX_N-1:0]   zero_vec;
    logic               tok;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= gss_pkg::SIZE_RST;
            r_tol  <= gss_pkg::TOL_RST;
            r_max  <= gss_pkg::SWEEP_RST;
        end else if (psel && penable && pwrite) begin
            unique case (gss_pkg::t_reg'(paddr[3:2]))
                gss_pkg::REG_SIZE:  r_size <= pwdata[4:0];
                gss_pkg::REG_TOL:   r_tol  <= pwdata[15:0];
                gss_pkg::REG_SWEEP: r_max  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (gss_pkg::t_reg'(paddr[3:2]))
            gss_pkg::REG_SIZE:  prdata = {27'd0, r_size};
            gss_pkg::REG_TOL:   prdata = {16'd0, r_tol};
            gss_pkg::REG_SWEEP: prdata = {16'd0, r_max};
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        if (r_size == 5'd0) begin
            eff_n = gss_pkg::N_W'(1);
        end else if ({2'd0, r_size} > gss_pkg::N_W'(MAX_N)) begin
            eff_n = gss_pkg::N_W'(MAX_N);
        end else begin
            eff_n = {2'd0, r_size};
        end
    end

    assign links[0].tok  = tok;
    assign links[0].acc  = '0;
    assign links[0].old  = '0;
    assign links[0].diag = '0;

    for (genvar k = 0; k < MAX_N; k++) begin : g_cell
        gss_cell #(.MAX_N(MAX_N), .K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_link  (links[k]),
            .o_link  (links[k+1]),
            .o_zero  (zero_vec[k])
        );
    end

    gss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (links[MAX_N].acc),
        .i_den   (links[MAX_N].diag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gss_ctl #(.MAX_N(MAX_N)) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_n         (eff_n),
        .i_tol       (r_tol),
        .i_max       (r_max),
        .i_any_zero  (|zero_vec),
        .i_chain     (links[MAX_N]),
        .i_div_done  (div_done),
        .i_div_quot  (div_quot),
        .o_ctl       (ctl),
        .o_tok       (tok),
        .o_div_start (div_start)
    );
endmodule
`default_nettype wire
